@@ rtl/ppue_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppue_pkg
// Shared types and constants of the particle pool update engine.
// ----------------------------------------------------------------------------
package ppue_pkg;

	localparam int SLOTS  = 64;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 152;

	// Ages are unsigned Q16.16; the lifespan is 5.0.
	localparam logic [31:0] LIFE_Q     = 32'd327680;
	localparam logic [33:0] ACCEL_STEP = 34'd33;

	// k * age > C is the same test as age > C / k for whole numbers.
	localparam logic [31:0] AGE_T1 = 32'(3276800 / 41);
	localparam logic [31:0] AGE_T2 = 32'(3276800 / 72);
	localparam logic [31:0] AGE_T3 = 32'(327680 / 12);

	// Box limits and spawn height, signed Q15.16.
	localparam logic signed [31:0] Y_HI    = -32'sd655360;
	localparam logic signed [31:0] Y_LO    = -32'sd5898240;
	localparam logic signed [31:0] X_HI    = 32'sd1638400;
	localparam logic signed [31:0] X_LO    = -32'sd1638400;
	localparam logic signed [31:0] Z_HI    = 32'sd655360;
	localparam logic signed [31:0] Z_LO    = -32'sd983040;
	localparam logic signed [31:0] SPAWN_Y = -32'sd1114112;

	localparam logic signed [17:0] OP_ONE = 18'sd65536;
	localparam logic signed [19:0] OP_MIN = -20'sd65536;

	typedef enum logic [0:0] {
		CMD_SPAWN = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TICK
	} state_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [15:0]        vel_x;
		logic [15:0]        vel_y;
		logic [15:0]        vel_z;
		logic signed [31:0] accel_y;
		logic [31:0]        age;
		logic signed [17:0] opacity;
	} slot_t;

	localparam slot_t SLOT_RESET = '{
		pos_x: '0, pos_y: '0, pos_z: '0,
		vel_x: '0, vel_y: '0, vel_z: '0,
		accel_y: '0, age: LIFE_Q, opacity: '0
	};

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic signed [17:0] alpha;
		logic               alive;
	} result_t;

	// Saturates a 34-bit two's complement sum to 32 bits.
	function automatic logic [31:0] sat32(input logic [33:0] v);
		logic [31:0] r;
		if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
			r = v[31:0];
		end else if (v[33]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7FFF_FFFF;
		end
		return r;
	endfunction

	function automatic logic [31:0] sat_age(input logic [32:0] v);
		return v[32] ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

@@ rtl/particle_pool_update_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_pool_update_engine_core
// Pool of particle slots in one RAM, updated by spawn and tick items.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the command (spawn or tick), tdata the time step,
// palette, spawn velocities and start x. Output stream: one item per slot on a
// tick, slot 0 first, tlast on the final slot; a spawn gives no output.
// All slot state lives in a single RAM word per slot, read through a
// registered read port. A tick reads, updates and writes back one slot per
// cycle while the receiver keeps up. A spawn scans the slots round-robin from
// the last slot claimed, one RAM read per cycle, and finishes at the first
// dead slot it finds, or after all slots when none is dead. The next item is
// taken in the cycle after the previous one finishes; the output register
// may still hold the last result at that time.
// Reset clears a valid flag per slot; a slot never written reads as dead with
// all other state zero, so no clearing pass is needed.
// A stalled receiver holds the output item and pauses the slot sweep.
// ----------------------------------------------------------------------------
module particle_pool_update_engine_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// dt[15:0], red_palette[16], vel_x[32:17], vel_y[48:33], vel_z[64:49],
	// start_x[68:65], zero fill above
	input  logic [ppue_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// command[0]
	input  logic [0:0]                           s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// slot[5:0], pos_x[37:6], pos_y[69:38], pos_z[101:70], red[109:102],
	// green[117:110], blue[125:118], alpha[143:126], alive[144], zero fill above
	output logic [ppue_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                 m_axis_tlast
);

	import ppue_pkg::*;

	localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(SLOTS);
	localparam logic [SLOT_W:0]   WRAP     = (SLOT_W + 1)'(SLOTS);
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q;
	logic              s1_vld_q;
	logic [SLOT_W-1:0] s1_slot_q;
	logic              s1_init_q;
	logic [SLOT_W-1:0] search_q;
	logic [SLOTS-1:0]  valid_q;

	logic [15:0]       dt_q;
	logic              red_q;
	logic [15:0]       vel_x_q, vel_y_q, vel_z_q;
	logic [3:0]        start_x_q;

	logic              m_tvalid_q;
	result_t           out_res_q;
	logic [5:0]        out_slot_q;
	logic              out_last_q;

	logic              accept;
	logic              rd_en, wr_en, load_out, fin;
	logic [SLOT_W-1:0] rd_addr, wr_addr;
	slot_t             wr_data, rd_data, cur, upd_nxt, spawn_w;
	result_t           upd_res;
	logic [SLOT_W:0]   scan_sum;
	logic [SLOT_W-1:0] scan_addr;
	logic              out_free;

	ppue_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	ppue_update u_update (
		.cur        (cur),
		.dt         (dt_q),
		.red_palette(red_q),
		.nxt        (upd_nxt),
		.res        (upd_res)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// A slot never written since reset reads as the reset state.
	assign cur      = s1_init_q ? rd_data : SLOT_RESET;
	assign out_free = !m_tvalid_q || m_axis_tready;

	assign scan_sum  = {1'b0, search_q} + cnt_q[SLOT_W-1:0];
	assign scan_addr = (scan_sum >= WRAP) ? SLOT_W'(scan_sum - WRAP) : scan_sum[SLOT_W-1:0];

	always_comb begin
		spawn_w         = SLOT_RESET;
		spawn_w.pos_x   = {{12{start_x_q[3]}}, start_x_q, 16'b0};
		spawn_w.pos_y   = SPAWN_Y;
		spawn_w.pos_z   = '0;
		spawn_w.vel_x   = vel_x_q;
		spawn_w.vel_y   = vel_y_q;
		spawn_w.vel_z   = vel_z_q;
		spawn_w.accel_y = '0;
		spawn_w.age     = '0;
		spawn_w.opacity = OP_ONE;
	end

	always_comb begin
		logic dead;
		logic issue;

		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = spawn_w;
		load_out = 1'b0;
		fin      = 1'b0;
		dead     = 1'b0;
		issue    = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = (cmd_e'(s_axis_tuser[0]) == CMD_TICK) ? ST_TICK : ST_SCAN;
				end
			end
			ST_SCAN: begin
				dead = s1_vld_q && (cur.age >= LIFE_Q);
				fin  = s1_vld_q && (dead || cnt_q == CNT_END);
				if (fin) begin
					// With no dead slot found, slot 0 is overwritten.
					wr_en   = 1'b1;
					wr_addr = dead ? s1_slot_q : '0;
					state_d = ST_IDLE;
				end else if (cnt_q < CNT_END) begin
					rd_en   = 1'b1;
					rd_addr = scan_addr;
				end
			end
			ST_TICK: begin
				load_out = s1_vld_q && out_free;
				issue    = (cnt_q < CNT_END) && (!s1_vld_q || load_out);
				rd_en    = issue;
				rd_addr  = cnt_q[SLOT_W-1:0];
				if (load_out) begin
					wr_en   = 1'b1;
					wr_addr = s1_slot_q;
					wr_data = upd_nxt;
				end
				if (!issue && cnt_q == CNT_END && (load_out || !s1_vld_q)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			s1_vld_q   <= 1'b0;
			s1_slot_q  <= '0;
			s1_init_q  <= 1'b0;
			search_q   <= '0;
			valid_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			if (rd_en) begin
				s1_vld_q  <= 1'b1;
				s1_slot_q <= rd_addr;
				s1_init_q <= valid_q[rd_addr];
			end else if (load_out || fin) begin
				s1_vld_q <= 1'b0;
			end

			if (fin) begin
				search_q <= wr_addr;
			end

			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end

			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dt_q      <= s_axis_tdata[15:0];
			red_q     <= s_axis_tdata[16];
			vel_x_q   <= s_axis_tdata[32:17];
			vel_y_q   <= s_axis_tdata[48:33];
			vel_z_q   <= s_axis_tdata[64:49];
			start_x_q <= s_axis_tdata[68:65];
		end
		if (load_out) begin
			out_res_q  <= upd_res;
			out_slot_q <= 6'(s1_slot_q);
			out_last_q <= (s1_slot_q == LAST_IDX);
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {7'b0, out_res_q.alive, out_res_q.alpha, out_res_q.blue,
		out_res_q.green, out_res_q.red, out_res_q.pos_z, out_res_q.pos_y,
		out_res_q.pos_x, out_slot_q};

endmodule

@@ rtl/ppue_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppue_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ppue_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/ppue_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppue_update
// One tick step of a single particle slot: age, motion, color, fade and kill.
// ----------------------------------------------------------------------------
module ppue_update (
	input  ppue_pkg::slot_t   cur,
	input  logic [15:0]       dt,
	input  logic              red_palette,
	output ppue_pkg::slot_t   nxt,
	output ppue_pkg::result_t res
);

	import ppue_pkg::*;

	always_comb begin
		logic [31:0]        age1;
		logic [31:0]        age2;
		logic [33:0]        sum_x;
		logic [33:0]        sum_y;
		logic [33:0]        sum_z;
		logic [33:0]        sum_a;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [19:0] op;
		logic               kill;

		age1 = sat_age({1'b0, cur.age} + {17'b0, dt});

		sum_x = {{2{cur.pos_x[31]}}, cur.pos_x} + {18'b0, cur.vel_x};
		sum_y = {{2{cur.pos_y[31]}}, cur.pos_y} + {18'b0, cur.vel_y}
			+ {{2{cur.accel_y[31]}}, cur.accel_y};
		sum_z = {{2{cur.pos_z[31]}}, cur.pos_z} + {18'b0, cur.vel_z};
		sum_a = {{2{cur.accel_y[31]}}, cur.accel_y} + ACCEL_STEP;

		px = $signed(sat32(sum_x));
		py = $signed(sat32(sum_y));
		pz = $signed(sat32(sum_z));

		op = $signed({{2{cur.opacity[17]}}, cur.opacity}) - $signed({6'b0, dt[15:2]});
		if (op < OP_MIN) begin
			op = OP_MIN;
		end

		kill = (age1 > LIFE_Q) || (py > Y_HI) || (py < Y_LO) || (px > X_HI)
			|| (px < X_LO) || (pz > Z_HI) || (pz < Z_LO);
		age2 = kill ? sat_age({1'b0, age1} + {1'b0, LIFE_Q}) : age1;

		nxt         = cur;
		nxt.pos_x   = px;
		nxt.pos_y   = py;
		nxt.pos_z   = pz;
		nxt.accel_y = $signed(sat32(sum_a));
		nxt.age     = age2;
		nxt.opacity = op[17:0];

		res.pos_x = px;
		res.pos_y = py;
		res.pos_z = pz;
		res.alpha = op[17:0];
		res.alive = (age2 < LIFE_Q);

		// The color follows the age before the kill penalty is added.
		priority if (age1 > AGE_T1) begin
			res.red   = red_palette ? 8'd255 : 8'd0;
			res.green = red_palette ? 8'd64 : 8'd128;
			res.blue  = 8'd0;
		end else if (age1 > AGE_T2) begin
			res.red   = red_palette ? 8'd255 : 8'd128;
			res.green = red_palette ? 8'd128 : 8'd255;
			res.blue  = 8'd0;
		end else if (age1 > AGE_T3) begin
			res.red   = red_palette ? 8'd255 : 8'd128;
			res.green = 8'd255;
			res.blue  = 8'd0;
		end else begin
			res.red   = 8'd255;
			res.green = 8'd242;
			res.blue  = 8'd204;
		end
	end

endmodule
